/* hw/rtl/dfsp_pkg.sv */
// shared constants and types for the dac fifo sound port
package dfsp_pkg;

   localparam int FIFO_DEPTH = 2048;
   localparam int ADDR_W     = $clog2(FIFO_DEPTH);
   localparam int PTR_W      = ADDR_W + 1;
   localparam int LWM_W      = 10;
   localparam int CMP_W      = (PTR_W > LWM_W) ? PTR_W : LWM_W;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [2:0] PORT_DATA   = 3'd0;
   localparam logic [2:0] PORT_ID     = 3'd1;
   localparam logic [2:0] PORT_STATUS = 3'd2;
   localparam logic [2:0] PORT_TIMER  = 3'd3;
   localparam logic [2:0] PORT_LWM    = 3'd4;

   localparam logic [7:0] ID_BYTE = 8'hff;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

endpackage

/* hw/rtl/dfsp_sample_store.sv */
// sample fifo storage with a registered read of the head entry
module dfsp_sample_store (
   input  logic                       clock,
   input  logic                       reset,
   input  dfsp_pkg::ram_wr_type       wr,
   input  logic [dfsp_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                 head_data
);

   logic [7:0] mem [dfsp_pkg::FIFO_DEPTH];
   logic [7:0] rd_q_ff;
   logic [7:0] byp_data_ff;
   logic       byp_ff;
   logic       byp_in;

   assign byp_in = wr.en && (wr.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_q_ff     <= mem[rd_addr];
      byp_data_ff <= wr.data;
   end

   // a write to the entry being read shows up on the next cycle through the bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign head_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

/* hw/rtl/dac_fifo_sound_port_top.sv */
// top level of the dac fifo sound port
// Each transaction (bus read, bus write or microsecond tick) passes through the input
// register and then the result register, and a new transaction is taken every cycle
// while the result side does not stall. The sample fifo lives in a
// single-port-write memory whose head entry is read ahead into a register every cycle, so a
// pop on timer expiry never waits on the memory. The memory needs no clearing after reset;
// transactions are taken from the first cycle out of reset.
module dac_fifo_sound_port_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [2:0]        req_port,
   input  logic [7:0]        req_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_rdata,
   output logic              rsp_irq,
   output logic signed [12:0] rsp_dac_sample
);

   localparam int PW = dfsp_pkg::PTR_W;
   localparam int AW = dfsp_pkg::ADDR_W;
   localparam int LW = dfsp_pkg::LWM_W;
   localparam int CW = dfsp_pkg::CMP_W;

   // input register
   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [2:0] in_port_ff;
   logic [7:0] in_wdata_ff;

   // result register
   logic              out_valid_ff;
   logic [7:0]        out_rdata_ff;
   logic              out_irq_ff;
   logic signed [12:0] out_dac_ff;

   // block state
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [7:0]    ctrl_ff, ctrl_in;
   logic          ae_ff, ae_in;
   logic          adc_ff, adc_in;
   logic [7:0]    reload_ff, reload_in;
   logic [7:0]    count_ff, count_in;
   logic          run_ff, run_in;
   logic [LW-1:0] lwm_ff, lwm_in;
   logic [7:0]    dac_ff, dac_in;

   logic          advance;
   logic          fire;
   logic          expire;
   logic [PW-1:0] fill;
   logic [PW-1:0] fill_after;
   logic          full;
   logic          empty;
   logic [7:0]    status;
   logic [7:0]    rdata_in;
   logic          irq_in;
   logic [12:0]   dac_sample_in;
   logic [7:0]    head_data;
   dfsp_pkg::ram_wr_type ram_wr;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign fill       = wp_ff - rp_ff;
   assign full       = (fill == PW'(dfsp_pkg::FIFO_DEPTH));
   assign empty      = (rp_ff == wp_ff);
   assign fill_after = empty ? fill : fill - PW'(1);
   assign status     = {3'b000, adc_ff, full, empty, ae_ff, ctrl_ff[0]};

   always_comb begin
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      ctrl_in   = ctrl_ff;
      ae_in     = ae_ff;
      adc_in    = adc_ff;
      reload_in = reload_ff;
      count_in  = count_ff;
      run_in    = run_ff;
      lwm_in    = lwm_ff;
      dac_in    = dac_ff;
      rdata_in  = 8'h00;
      expire    = 1'b0;
      ram_wr    = '0;
      ram_wr.addr = wp_ff[AW-1:0];
      ram_wr.data = in_wdata_ff;
      if (fire) begin
         case (in_cmd_ff)
            dfsp_pkg::CMD_READ: begin
               case (in_port_ff)
                  dfsp_pkg::PORT_DATA:   adc_in   = 1'b0;
                  dfsp_pkg::PORT_ID:     rdata_in = dfsp_pkg::ID_BYTE;
                  dfsp_pkg::PORT_STATUS: rdata_in = status;
                  dfsp_pkg::PORT_TIMER:  rdata_in = reload_ff;
                  default:               rdata_in = 8'h00;
               endcase
            end
            dfsp_pkg::CMD_WRITE: begin
               case (in_port_ff)
                  dfsp_pkg::PORT_DATA: begin
                     if (!full) begin
                        ram_wr.en = 1'b1;
                        wp_in     = wp_ff + PW'(1);
                     end
                  end
                  dfsp_pkg::PORT_STATUS: begin
                     ctrl_in = in_wdata_ff;
                     if (!in_wdata_ff[1]) begin
                        ae_in = 1'b0;
                     end
                  end
                  dfsp_pkg::PORT_TIMER: begin
                     reload_in = in_wdata_ff;
                     if (in_wdata_ff != 8'h00) begin
                        count_in = 8'hff - in_wdata_ff;
                        run_in   = 1'b1;
                     end else begin
                        count_in = 8'h00;
                        run_in   = 1'b0;
                     end
                  end
                  dfsp_pkg::PORT_LWM: lwm_in = {in_wdata_ff, 2'b00};
                  default: ;
               endcase
            end
            dfsp_pkg::CMD_TICK: begin
               if (run_ff) begin
                  if (count_ff > 8'd1) begin
                     count_in = count_ff - 8'd1;
                  end else begin
                     expire   = 1'b1;
                     count_in = reload_ff;
                  end
               end
            end
            default: ;
         endcase
         if (expire) begin
            if (!empty) begin
               dac_in = head_data;
               rp_in  = rp_ff + PW'(1);
            end
            if (CW'(fill_after) == CW'(lwm_ff)) begin
               ae_in = 1'b1;
            end
            adc_in = 1'b1;
         end
      end
   end

   assign irq_in        = ((ae_in && ctrl_in[1]) || (adc_in && ctrl_in[4])) && ctrl_in[0];
   assign dac_sample_in = {~dac_in[7], dac_in[6:0], 5'b00000};

   dfsp_sample_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr        (ram_wr),
      .rd_addr   (rp_in[AW-1:0]),
      .head_data (head_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         ctrl_ff      <= 8'h00;
         ae_ff        <= 1'b0;
         adc_ff       <= 1'b0;
         reload_ff    <= 8'h00;
         count_ff     <= 8'h00;
         run_ff       <= 1'b0;
         lwm_ff       <= '0;
         dac_ff       <= 8'h00;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         ctrl_ff   <= ctrl_in;
         ae_ff     <= ae_in;
         adc_ff    <= adc_in;
         reload_ff <= reload_in;
         count_ff  <= count_in;
         run_ff    <= run_in;
         lwm_ff    <= lwm_in;
         dac_ff    <= dac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cmd_ff   <= req_cmd;
         in_port_ff  <= req_port;
         in_wdata_ff <= req_wdata;
      end
      if (fire) begin
         out_rdata_ff <= rdata_in;
         out_irq_ff   <= irq_in;
         out_dac_ff   <= signed'(dac_sample_in);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_rdata      = out_rdata_ff;
   assign rsp_irq        = out_irq_ff;
   assign rsp_dac_sample = out_dac_ff;

   // fill level never exceeds the fifo depth
   assert property (@(posedge clock) disable iff (reset)
      fill <= PW'(dfsp_pkg::FIFO_DEPTH))
      else $error("fifo fill level beyond depth");

   // a stopped timer always holds a zero count
   assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> (count_ff == 8'h00))
      else $error("stopped timer with nonzero count");

   // no push lands in a full fifo
   assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> (!full && fire))
      else $error("push into full fifo");

   // an expiry on a nonempty fifo pops exactly one sample
   assert property (@(posedge clock) disable iff (reset)
      (expire && !empty) |=> (rp_ff == $past(rp_ff) + PW'(1)))
      else $error("expiry did not advance read pointer");

   // input side only stalls while a transaction waits in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff))
      else $error("stall without a held transaction");

endmodule
